// ----- src/absolute_loader_tape_parser_unit_defines.svh -----
// Assertion macros shared by the tape parser modules.
`ifndef ABSOLUTE_LOADER_TAPE_PARSER_UNIT_DEFINES_SVH
`define ABSOLUTE_LOADER_TAPE_PARSER_UNIT_DEFINES_SVH

// The condition must hold at every clock edge outside reset.
`define ALTP_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define ALTP_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ALTP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/altp_pkg.sv -----
package altp_pkg;

   localparam int ODD_SLOTS_DEFAULT = 4;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] LEADER_BYTE = 8'h01;
   localparam logic [15:0] MIN_COUNT = 16'd6;

   typedef enum logic [2:0] {
      KIND_WRITE = 3'd0,
      KIND_GOOD  = 3'd1,
      KIND_START = 3'd2,
      KIND_END   = 3'd3,
      KIND_ERROR = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      ERR_START_BYTE  = 3'd0,
      ERR_SECOND_BYTE = 3'd1,
      ERR_CHECKSUM    = 3'd2,
      ERR_EARLY_END   = 3'd3,
      ERR_SHORT_COUNT = 3'd4
   } err_type;

   typedef enum logic [7:0] {
      PH_CHR0   = 8'b0000_0001,
      PH_CHR1   = 8'b0000_0010,
      PH_CNTLO  = 8'b0000_0100,
      PH_CNTHI  = 8'b0000_1000,
      PH_ADRLO  = 8'b0001_0000,
      PH_ADRHI  = 8'b0010_0000,
      PH_DATA   = 8'b0100_0000,
      PH_CHKSUM = 8'b1000_0000
   } phase_type;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] address;
      logic [15:0] word;
      err_type     error_code;
      logic        last;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

   typedef struct packed {
      logic        en;
      logic [15:0] address;
      logic [7:0]  low;
   } odd_rec_type;

endpackage

// ----- src/altp_odd_table.sv -----
`include "absolute_loader_tape_parser_unit_defines.svh"

module altp_odd_table #(
   parameter int ODD_SLOTS = altp_pkg::ODD_SLOTS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [15:0]         lookup_address,
   output logic [7:0]          lookup_low,
   input  altp_pkg::odd_rec_type rec
);
   import altp_pkg::*;

   localparam int SW = (ODD_SLOTS > 1) ? $clog2(ODD_SLOTS) : 1;

   logic              valid_ff [ODD_SLOTS];
   logic [15:0]       addr_ff  [ODD_SLOTS];
   logic [7:0]        low_ff   [ODD_SLOTS];
   logic [SW-1:0]     victim_ff, victim_in;
   logic              rec_hit;
   logic [SW-1:0]     rec_index, wr_index;

   always_comb begin
      lookup_low = 8'h00;
      for (int i = ODD_SLOTS - 1; i >= 0; i--) begin
         if (valid_ff[i] && addr_ff[i] == lookup_address) begin
            lookup_low = low_ff[i];
         end
      end
   end

   always_comb begin
      rec_hit   = 1'b0;
      rec_index = '0;
      for (int i = ODD_SLOTS - 1; i >= 0; i--) begin
         if (valid_ff[i] && addr_ff[i] == rec.address) begin
            rec_hit   = 1'b1;
            rec_index = SW'(i);
         end
      end
      wr_index  = rec_hit ? rec_index : victim_ff;
      victim_in = victim_ff;
      if (rec.en && !rec_hit) begin
         victim_in = (victim_ff == SW'(ODD_SLOTS - 1)) ? '0 : SW'(victim_ff + 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         victim_ff <= '0;
         for (int i = 0; i < ODD_SLOTS; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         victim_ff <= victim_in;
         if (rec.en) begin
            valid_ff[wr_index] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rec.en) begin
         addr_ff[wr_index] <= rec.address;
         low_ff[wr_index]  <= rec.low;
      end
   end

   `ALTP_ASSERT_ALWAYS(a_victim_range, victim_ff <= SW'(ODD_SLOTS - 1), "victim out of range")

endmodule

// ----- src/altp_parser.sv -----
`include "absolute_loader_tape_parser_unit_defines.svh"

module altp_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_data_byte,
   input  logic                  req_stream_end,
   input  logic                  room,
   output altp_pkg::push_type    push,
   output logic [15:0]           lookup_address,
   input  logic [7:0]            lookup_low,
   output altp_pkg::odd_rec_type rec
);
   import altp_pkg::*;

   logic        in_vld_ff, in_vld_in;
   logic [7:0]  in_byte_ff;
   logic        in_end_ff;
   logic        fire, accept;

   phase_type   phase_ff, phase_in;
   logic        stopped_ff, stopped_in;
   logic [15:0] count_ff, count_in;
   logic [15:0] load_ff, load_in;
   logic [15:0] cur_ff, cur_in;
   logic [15:0] acc_ff, acc_in;
   logic [7:0]  sum_ff, sum_in;
   logic [15:0] index_ff, index_in;
   logic [15:0] new_count, new_load, data_word;

   assign fire      = in_vld_ff && room;
   assign req_stall = in_vld_ff && !room;
   assign accept    = req_valid && !req_stall;
   assign in_vld_in = accept ? 1'b1 : (fire ? 1'b0 : in_vld_ff);

   assign new_count      = {in_byte_ff, count_ff[7:0]};
   assign new_load       = {in_byte_ff, load_ff[7:0]};
   assign data_word      = {in_byte_ff, acc_ff[7:0]};
   assign lookup_address = new_load;

   always_comb begin
      phase_in   = phase_ff;
      stopped_in = stopped_ff;
      count_in   = count_ff;
      load_in    = load_ff;
      cur_in     = cur_ff;
      acc_in     = acc_ff;
      sum_in     = sum_ff;
      index_in   = index_ff;
      push       = '0;
      rec        = '0;
      if (fire && !stopped_ff) begin
         if (in_end_ff) begin
            stopped_in        = 1'b1;
            push.count        = 2'd1;
            push.first.last   = 1'b1;
            if (phase_ff == PH_CHR0) begin
               push.first.kind = KIND_END;
            end else begin
               push.first.kind       = KIND_ERROR;
               push.first.error_code = ERR_EARLY_END;
            end
         end else begin
            index_in = index_ff + 16'd1;
            sum_in   = sum_ff + in_byte_ff;
            case (phase_ff)
               PH_CHR0: begin
                  if (in_byte_ff == 8'h00) begin
                     index_in = '0;
                  end else if (in_byte_ff == LEADER_BYTE) begin
                     phase_in = PH_CHR1;
                  end else begin
                     stopped_in            = 1'b1;
                     push.count            = 2'd1;
                     push.first.kind       = KIND_ERROR;
                     push.first.error_code = ERR_START_BYTE;
                     push.first.last       = 1'b1;
                  end
               end
               PH_CHR1: begin
                  if (in_byte_ff == 8'h00) begin
                     phase_in = PH_CNTLO;
                  end else begin
                     stopped_in            = 1'b1;
                     push.count            = 2'd1;
                     push.first.kind       = KIND_ERROR;
                     push.first.error_code = ERR_SECOND_BYTE;
                     push.first.last       = 1'b1;
                  end
               end
               PH_CNTLO: begin
                  count_in = {8'h00, in_byte_ff};
                  phase_in = PH_CNTHI;
               end
               PH_CNTHI: begin
                  count_in = new_count;
                  if (new_count < MIN_COUNT) begin
                     stopped_in            = 1'b1;
                     push.count            = 2'd1;
                     push.first.kind       = KIND_ERROR;
                     push.first.error_code = ERR_SHORT_COUNT;
                     push.first.last       = 1'b1;
                  end else begin
                     phase_in = PH_ADRLO;
                  end
               end
               PH_ADRLO: begin
                  load_in  = {8'h00, in_byte_ff};
                  phase_in = PH_ADRHI;
               end
               PH_ADRHI: begin
                  load_in  = new_load;
                  cur_in   = new_load;
                  acc_in   = (new_load[0] && count_ff > MIN_COUNT) ?
                             {8'h00, lookup_low} : 16'h0000;
                  phase_in = (count_ff == MIN_COUNT) ? PH_CHKSUM : PH_DATA;
               end
               PH_DATA: begin
                  if (!cur_ff[0]) begin
                     acc_in = {8'h00, in_byte_ff};
                  end else begin
                     acc_in             = data_word;
                     push.count         = 2'd1;
                     push.first.kind    = KIND_WRITE;
                     push.first.address = {cur_ff[15:1], 1'b0};
                     push.first.word    = data_word;
                     push.first.last    = 1'b1;
                  end
                  cur_in = cur_ff + 16'd1;
                  if (index_ff == count_ff - 16'd1) begin
                     phase_in = PH_CHKSUM;
                  end
               end
               PH_CHKSUM: begin
                  index_in = '0;
                  phase_in = PH_CHR0;
                  if (sum_in != 8'h00) begin
                     stopped_in            = 1'b1;
                     push.count            = 2'd1;
                     push.first.kind       = KIND_ERROR;
                     push.first.error_code = ERR_CHECKSUM;
                     push.first.last       = 1'b1;
                  end else if (count_ff == MIN_COUNT) begin
                     stopped_in         = 1'b1;
                     push.count         = 2'd1;
                     push.first.kind    = KIND_START;
                     push.first.address = load_ff;
                     push.first.last    = 1'b1;
                  end else if (cur_ff[0]) begin
                     push.count          = 2'd2;
                     push.first.kind     = KIND_WRITE;
                     push.first.address  = {cur_ff[15:1], 1'b0};
                     push.first.word     = {8'h00, acc_ff[7:0]};
                     push.second.kind    = KIND_GOOD;
                     push.second.last    = 1'b1;
                     rec.en              = 1'b1;
                     rec.address         = cur_ff;
                     rec.low             = acc_ff[7:0];
                  end else begin
                     push.count      = 2'd1;
                     push.first.kind = KIND_GOOD;
                     push.first.last = 1'b1;
                  end
               end
               default: begin
                  phase_in = PH_CHR0;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         phase_ff   <= PH_CHR0;
         stopped_ff <= 1'b0;
         count_ff   <= '0;
         load_ff    <= '0;
         cur_ff     <= '0;
         acc_ff     <= '0;
         sum_ff     <= '0;
         index_ff   <= '0;
      end else begin
         in_vld_ff  <= in_vld_in;
         phase_ff   <= phase_in;
         stopped_ff <= stopped_in;
         count_ff   <= count_in;
         load_ff    <= load_in;
         cur_ff     <= cur_in;
         acc_ff     <= acc_in;
         sum_ff     <= sum_in;
         index_ff   <= index_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_data_byte;
         in_end_ff  <= req_stream_end;
      end
   end

   `ALTP_ASSERT_IMPL(a_quiet_when_stopped, stopped_ff, push.count == 2'd0, "result after stop")
   `ALTP_ASSERT_IMPL(a_pair_shape, push.count == 2'd2,
      push.first.kind == KIND_WRITE && push.second.kind == KIND_GOOD, "bad result pair")
   `ALTP_ASSERT_NEXT(a_stop_sticks, stopped_ff, stopped_ff, "stop flag cleared")

endmodule

// ----- src/altp_rsp_queue.sv -----
`include "absolute_loader_tape_parser_unit_defines.svh"

module altp_rsp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  altp_pkg::push_type   push,
   output logic                 room,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output altp_pkg::result_type head
);
   import altp_pkg::*;

   result_type        mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              pop;

   assign rsp_valid = (count_ff != '0);
   assign head      = mem_ff[rd_ff];
   assign pop       = rsp_valid && !rsp_stall;
   assign room      = (count_ff <= QCNT_W'(QUEUE_DEPTH - 2));

   always_comb begin
      wr_in    = QPTR_W'(wr_ff + push.count);
      rd_in    = pop ? QPTR_W'(rd_ff + 1'b1) : rd_ff;
      count_in = QCNT_W'(count_ff + push.count - {{(QCNT_W-1){1'b0}}, pop});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[QPTR_W'(wr_ff + 1'b1)] <= push.second;
      end
   end

   `ALTP_ASSERT_ALWAYS(a_no_overflow, count_ff <= QCNT_W'(QUEUE_DEPTH), "queue overflow")
   `ALTP_ASSERT_IMPL(a_push_has_room, push.count != 2'd0,
      count_ff <= QCNT_W'(QUEUE_DEPTH - 2), "push without room")

endmodule

// ----- src/absolute_loader_tape_parser_unit.sv -----
// A byte is held in an input register after acceptance and is parsed from there once the
// result queue has room; its results are registered in the queue and offered from its head.
// Throughput: one byte per cycle while the result queue has room; a byte with two results
// needs two buffered rsp beats; the four-entry queue stalls input when fewer than two are free.
// Reset is synchronous and active high; it clears the parser state and invalidates the
// odd-byte table at once, so the block takes bytes as soon as reset is released.
module absolute_loader_tape_parser_unit #(
   parameter int ODD_SLOTS = altp_pkg::ODD_SLOTS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_stream_end,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_kind,
   output logic [15:0] rsp_address,
   output logic [15:0] rsp_word,
   output logic [2:0]  rsp_error_code,
   output logic        rsp_last
);
   import altp_pkg::*;

   push_type    push;
   odd_rec_type rec;
   result_type  head;
   logic        room;
   logic [15:0] lookup_address;
   logic [7:0]  lookup_low;

   altp_parser u_parser (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_byte  (req_data_byte),
      .req_stream_end (req_stream_end),
      .room           (room),
      .push           (push),
      .lookup_address (lookup_address),
      .lookup_low     (lookup_low),
      .rec            (rec)
   );

   altp_odd_table #(
      .ODD_SLOTS (ODD_SLOTS)
   ) u_odd_table (
      .clock          (clock),
      .reset          (reset),
      .lookup_address (lookup_address),
      .lookup_low     (lookup_low),
      .rec            (rec)
   );

   altp_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .head      (head)
   );

   assign rsp_kind       = head.kind;
   assign rsp_address    = head.address;
   assign rsp_word       = head.word;
   assign rsp_error_code = head.error_code;
   assign rsp_last       = head.last;

endmodule
